@@ sv/spadf_pkg.sv @@
// Shared types and constants for the stack pool allocator with deferred free.
// Used by the channel interfaces, the top level and the testbench.
// No dependencies.
package spadf_pkg;

	localparam int OFFSET_W = 21;
	localparam int SIZE_W = 22;
	localparam int LIVE_W = 7;
	localparam int STATUS_W = 2;

	localparam int MAX_BLOCKS_DEF = 64;
	localparam int POOL_ADDR_BITS = 21;

	localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(2 * 1024 * 1024);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NOROOM   = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SRCH,
		S_CASC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [SIZE_W-1:0]   size;
		logic                released;
	} entry_t;

endpackage

@@ sv/spadf_if.sv @@
// Handshake channels of the allocator: request, response and capacity write.
// Each carries valid, ready and its payload. Depends on spadf_pkg.
interface spadf_req_if;
	logic                           valid;
	logic                           ready;
	logic                           func;
	logic [spadf_pkg::SIZE_W-1:0]   request_size;
	logic [spadf_pkg::OFFSET_W-1:0] free_offset;

	modport source (output valid, func, request_size, free_offset, input ready);
	modport sink (input valid, func, request_size, free_offset, output ready);
endinterface

interface spadf_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [spadf_pkg::STATUS_W-1:0] status;
	logic [spadf_pkg::OFFSET_W-1:0] alloc_offset;
	logic                           deferred;
	logic [spadf_pkg::LIVE_W-1:0]   live_blocks;
	logic [spadf_pkg::SIZE_W-1:0]   used_bytes;

	modport source (output valid, status, alloc_offset, deferred, live_blocks, used_bytes,
		input ready);
	modport sink (input valid, status, alloc_offset, deferred, live_blocks, used_bytes,
		output ready);
endinterface

interface spadf_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [spadf_pkg::SIZE_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ sv/stack_pool_allocator_deferred_free.sv @@
// Stack pool allocator with deferred free. One request word at a time.
// Allocate: the request is decided in the idle state and its result is loaded into the output
// register from the done state once that register is empty or being read. Free: one entry per
// cycle is read from the top of the stack, searching and then, if the top entry was freed,
// cascading, before the done state loads the result. The next word is taken once the
// result sits in the output register. Reset clears depth, pool top, sequencer and output valid,
// restores the full capacity and leaves the entry RAM as it is.
module stack_pool_allocator_deferred_free #(
	parameter int MAX_BLOCKS = spadf_pkg::MAX_BLOCKS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	spadf_req_if.sink   req,
	spadf_rsp_if.source rsp,
	spadf_cfg_if.sink   cfg
);

	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int DW = $clog2(MAX_BLOCKS + 1);
	localparam int EW = $bits(spadf_pkg::entry_t);
	localparam int OW = spadf_pkg::OFFSET_W;
	localparam int SW = spadf_pkg::SIZE_W;
	localparam logic [32:0] ADDR_LIM = 33'(1) << spadf_pkg::POOL_ADDR_BITS;

	spadf_pkg::state_t  state_q, state_d;
	logic [DW-1:0]      depth_q, depth_d;
	logic [SW-1:0]      top_q, top_d;
	logic [AW-1:0]      idx_q, idx_d;
	logic [SW-1:0]      cap_q;
	logic [OW-1:0]      foff_q;
	spadf_pkg::status_t res_status_q, res_status_d;
	logic [OW-1:0]      res_aoff_q, res_aoff_d;
	logic               res_def_q, res_def_d;

	logic               rsp_valid_q;
	spadf_pkg::status_t rsp_status_q;
	logic [OW-1:0]      rsp_aoff_q;
	logic               rsp_def_q;
	logic [DW-1:0]      rsp_live_q;
	logic [SW-1:0]      rsp_used_q;
	logic               load;

	logic               we;
	logic [AW-1:0]      waddr;
	spadf_pkg::entry_t  wentry;
	logic [EW-1:0]      rd_data;
	spadf_pkg::entry_t  rd_entry;

	logic [SW:0]        size_rnd;
	logic [SW+1:0]      alloc_end;
	logic [SW-1:0]      top_popped;

	spadf_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_BLOCKS)
	) u_entries (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(EW'(wentry)),
		.raddr(idx_d),
		.rdata(rd_data)
	);

	assign rd_entry = spadf_pkg::entry_t'(rd_data);

	assign size_rnd = ((SW+1)'(req.request_size) + (SW+1)'(3)) & ~((SW+1)'(3));
	assign alloc_end = (SW+2)'(top_q) + (SW+2)'(size_rnd);
	// The pool top never drops below zero when an entry is popped.
	assign top_popped = (top_q < rd_entry.size) ? '0 : top_q - rd_entry.size;

	assign req.ready = (state_q == spadf_pkg::S_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spadf_pkg::S_IDLE;
			depth_q <= '0;
			top_q <= '0;
			cap_q <= spadf_pkg::CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			top_q <= top_d;
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		res_status_q <= res_status_d;
		res_aoff_q <= res_aoff_d;
		res_def_q <= res_def_d;
		if (req.valid && req.ready) begin
			foff_q <= req.free_offset;
		end
		if (load) begin
			rsp_status_q <= res_status_q;
			rsp_aoff_q <= res_aoff_q;
			rsp_def_q <= res_def_q;
			rsp_live_q <= depth_q;
			rsp_used_q <= top_q;
		end
	end

	always_comb begin
		state_d = state_q;
		depth_d = depth_q;
		top_d = top_q;
		idx_d = idx_q;
		res_status_d = res_status_q;
		res_aoff_d = res_aoff_q;
		res_def_d = res_def_q;
		we = 1'b0;
		waddr = idx_q;
		wentry = rd_entry;
		load = 1'b0;

		unique case (state_q)
			spadf_pkg::S_IDLE: begin
				if (req.valid) begin
					res_aoff_d = '0;
					res_def_d = 1'b0;
					res_status_d = spadf_pkg::ST_OK;
					state_d = spadf_pkg::S_DONE;
					if (!req.func) begin
						if ((alloc_end > (SW+2)'(cap_q)) || (33'(top_q) >= ADDR_LIM)) begin
							res_status_d = spadf_pkg::ST_NOROOM;
						end else if (depth_q == DW'(MAX_BLOCKS)) begin
							res_status_d = spadf_pkg::ST_FULL;
						end else begin
							we = 1'b1;
							waddr = AW'(depth_q);
							wentry.offset = OW'(top_q);
							wentry.size = SW'(size_rnd);
							wentry.released = 1'b0;
							depth_d = depth_q + DW'(1);
							top_d = SW'(alloc_end);
							res_aoff_d = OW'(top_q);
						end
					end else if (depth_q == '0) begin
						res_status_d = spadf_pkg::ST_NOTFOUND;
					end else begin
						idx_d = AW'(depth_q - DW'(1));
						state_d = spadf_pkg::S_SRCH;
					end
				end
			end
			spadf_pkg::S_SRCH: begin
				// The read word holds the entry at idx_q, issued in the previous cycle.
				if ((rd_entry.offset == foff_q) && !rd_entry.released) begin
					if ((DW'(idx_q) + DW'(1)) == depth_q) begin
						depth_d = DW'(idx_q);
						top_d = top_popped;
						if (idx_q == '0) begin
							state_d = spadf_pkg::S_DONE;
						end else begin
							idx_d = idx_q - AW'(1);
							state_d = spadf_pkg::S_CASC;
						end
					end else begin
						we = 1'b1;
						wentry.released = 1'b1;
						res_def_d = 1'b1;
						state_d = spadf_pkg::S_DONE;
					end
				end else if (idx_q == '0) begin
					res_status_d = spadf_pkg::ST_NOTFOUND;
					state_d = spadf_pkg::S_DONE;
				end else begin
					idx_d = idx_q - AW'(1);
				end
			end
			spadf_pkg::S_CASC: begin
				// Entries already released below the popped top go with it.
				if (rd_entry.released) begin
					depth_d = depth_q - DW'(1);
					top_d = top_popped;
					if (depth_q == DW'(1)) begin
						state_d = spadf_pkg::S_DONE;
					end else begin
						idx_d = idx_q - AW'(1);
					end
				end else begin
					state_d = spadf_pkg::S_DONE;
				end
			end
			spadf_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load = 1'b1;
					state_d = spadf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = spadf_pkg::S_IDLE;
			end
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.alloc_offset = rsp_aoff_q;
	assign rsp.deferred = rsp_def_q;
	assign rsp.live_blocks = spadf_pkg::LIVE_W'(rsp_live_q);
	assign rsp.used_bytes = rsp_used_q;

endmodule

@@ sv/spadf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spadf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ dv/tb_stack_pool_allocator_deferred_free.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the stack pool allocator with deferred free.
// Depends on spadf_pkg, the spadf channel interfaces and the top level of the block.
module tb_stack_pool_allocator_deferred_free;

	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE = 1'b1;
	localparam int PLAN = 0;
	localparam int SHADOW = 1;
	localparam int PHASE_ITEMS = 175;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 2 * spadf_pkg::MAX_BLOCKS_DEF + 8;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic                           func;
		logic [spadf_pkg::SIZE_W-1:0]   size;
		logic [spadf_pkg::OFFSET_W-1:0] offset;
	} alloc_req_t;

	typedef struct packed {
		spadf_pkg::status_t             status;
		logic [spadf_pkg::OFFSET_W-1:0] alloc_offset;
		logic                           deferred;
		logic [spadf_pkg::LIVE_W-1:0]   live_blocks;
		logic [spadf_pkg::SIZE_W-1:0]   used_bytes;
	} alloc_rsp_t;

	logic clk;
	logic arst_n;

	spadf_req_if req_ch();
	spadf_rsp_if rsp_ch();
	spadf_cfg_if cfg_ch();

	stack_pool_allocator_deferred_free u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// Two copies of the allocator state: one runs ahead as the requests are planned,
	// the other follows the requests the block actually accepts.
	logic [spadf_pkg::OFFSET_W-1:0] ent_off [2][spadf_pkg::MAX_BLOCKS_DEF];
	int unsigned                    ent_len [2][spadf_pkg::MAX_BLOCKS_DEF];
	bit                             ent_freed [2][spadf_pkg::MAX_BLOCKS_DEF];
	int                             stack_depth [2];
	int unsigned                    pool_top [2];
	logic [spadf_pkg::SIZE_W-1:0]   pool_cap [2];

	alloc_req_t request_q[$];
	alloc_rsp_t pending_results[$];

	bit req_taken = 1'b0;
	bit no_idle = 1'b0;
	int hold_asks = 0;
	int holds_done = 0;
	int hold_left = 0;
	int errors = 0;
	int cycle_count = 0;
	int words_in = 0;
	int status_seen [4];
	int deferred_seen = 0;
	int full_depth_seen = 0;
	int cap_writes = 0;

	function automatic alloc_rsp_t apply_request(input int m, input alloc_req_t r);
		alloc_rsp_t  o;
		int unsigned rounded;
		int unsigned end_b;
		int          i;
		bit          hit;
		o = '0;
		o.status = spadf_pkg::ST_OK;
		if (r.func == FN_ALLOC) begin
			rounded = (32'(r.size) + 32'd3) & ~32'd3;
			end_b = pool_top[m] + rounded;
			if (end_b > 32'(pool_cap[m]) ||
				pool_top[m] >= (32'd1 << spadf_pkg::POOL_ADDR_BITS)) begin
				o.status = spadf_pkg::ST_NOROOM;
			end else if (stack_depth[m] >= spadf_pkg::MAX_BLOCKS_DEF) begin
				o.status = spadf_pkg::ST_FULL;
			end else begin
				ent_off[m][stack_depth[m]] = spadf_pkg::OFFSET_W'(pool_top[m]);
				ent_len[m][stack_depth[m]] = rounded;
				ent_freed[m][stack_depth[m]] = 1'b0;
				stack_depth[m]++;
				o.alloc_offset = spadf_pkg::OFFSET_W'(pool_top[m]);
				pool_top[m] = end_b;
			end
		end else begin
			hit = 1'b0;
			i = stack_depth[m];
			// The topmost live entry with this offset is the one that is freed.
			while (i > 0 && !hit) begin
				i--;
				if (ent_off[m][i] == r.offset && !ent_freed[m][i])
					hit = 1'b1;
			end
			if (!hit) begin
				o.status = spadf_pkg::ST_NOTFOUND;
			end else if (i + 1 == stack_depth[m]) begin
				do begin
					stack_depth[m]--;
					pool_top[m] = (ent_len[m][stack_depth[m]] > pool_top[m]) ? 0 :
						pool_top[m] - ent_len[m][stack_depth[m]];
				end while (stack_depth[m] > 0 && ent_freed[m][stack_depth[m] - 1]);
			end else begin
				ent_freed[m][i] = 1'b1;
				o.deferred = 1'b1;
			end
		end
		o.live_blocks = spadf_pkg::LIVE_W'(stack_depth[m]);
		o.used_bytes = spadf_pkg::SIZE_W'(pool_top[m]);
		return o;
	endfunction

	function automatic void queue_request(input logic func,
		input logic [spadf_pkg::SIZE_W-1:0] size, input logic [spadf_pkg::OFFSET_W-1:0] offset);
		alloc_req_t r;
		r.func = func;
		r.size = size;
		r.offset = offset;
		void'(apply_request(PLAN, r));
		request_q.insert(request_q.size(), r);
	endfunction

	// Random request against the planned state: allocations of mixed sizes, frees that
	// mostly name a recorded offset, half of them near the top, and some frees of random offsets.
	function automatic void queue_random(input int alloc_pct);
		logic [spadf_pkg::SIZE_W-1:0]   size;
		logic [spadf_pkg::OFFSET_W-1:0] offset;
		int unsigned                    room;
		int                             k;
		int                             span;
		int                             idx;
		size = spadf_pkg::SIZE_W'($urandom);
		offset = spadf_pkg::OFFSET_W'($urandom);
		k = $urandom_range(99);
		if (k < alloc_pct) begin
			case ($urandom_range(9))
				0: size = spadf_pkg::SIZE_W'($urandom);
				1, 2: begin
					room = (32'(pool_cap[PLAN]) > pool_top[PLAN]) ?
						32'(pool_cap[PLAN]) - pool_top[PLAN] : 0;
					size = spadf_pkg::SIZE_W'(room + $urandom_range(8) - 4);
				end
				3: size = '0;
				default: size = spadf_pkg::SIZE_W'($urandom_range(48, 1));
			endcase
			queue_request(FN_ALLOC, size, offset);
		end else begin
			if (k < 94 && stack_depth[PLAN] > 0) begin
				if ($urandom_range(1)) begin
					span = (stack_depth[PLAN] - 1 < 3) ? stack_depth[PLAN] - 1 : 3;
					idx = stack_depth[PLAN] - 1 - $urandom_range(span);
				end else begin
					idx = $urandom_range(stack_depth[PLAN] - 1);
				end
				offset = ent_off[PLAN][idx];
			end
			queue_request(FN_FREE, size, offset);
		end
	endfunction

	task automatic wait_drained;
		while (request_q.size() != 0 || req_ch.valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [spadf_pkg::SIZE_W-1:0] value);
		pool_cap[PLAN] = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		pool_cap[SHADOW] = value;
		cap_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic check_result(input alloc_rsp_t exp);
		if (rsp_ch.status !== exp.status) begin
			$error("status: expected %0d, got %0d", exp.status, rsp_ch.status);
			errors++;
		end
		if (rsp_ch.alloc_offset !== exp.alloc_offset) begin
			$error("alloc_offset: expected %0d, got %0d", exp.alloc_offset,
				rsp_ch.alloc_offset);
			errors++;
		end
		if (rsp_ch.deferred !== exp.deferred) begin
			$error("deferred: expected %0d, got %0d", exp.deferred, rsp_ch.deferred);
			errors++;
		end
		if (rsp_ch.live_blocks !== exp.live_blocks) begin
			$error("live_blocks: expected %0d, got %0d", exp.live_blocks, rsp_ch.live_blocks);
			errors++;
		end
		if (rsp_ch.used_bytes !== exp.used_bytes) begin
			$error("used_bytes: expected %0d, got %0d", exp.used_bytes, rsp_ch.used_bytes);
			errors++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Request driver: a word is held until it is taken, then the next one is offered or valid drops at random.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (request_q.size() != 0 && (no_idle || $urandom_range(99) >= 10)) begin
				req_ch.valid <= 1'b1;
				req_ch.func <= request_q[0].func;
				req_ch.request_size <= request_q[0].size;
				req_ch.free_offset <= request_q[0].offset;
				void'(request_q.pop_front());
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response ready, dropped at random, with one long hold-off counted here.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (hold_asks != holds_done) begin
			holds_done++;
			hold_left = HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= no_idle || $urandom_range(99) >= 10;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("run stopped after %0d cycles with %0d results outstanding", cycle_count,
				pending_results.size());
			$display("tb_stack_pool_allocator_deferred_free NOT OK");
			$finish;
		end else begin
			req_taken = arst_n && req_ch.valid && req_ch.ready;
			if (req_taken) begin
				pending_results.insert(pending_results.size(), apply_request(SHADOW,
					{req_ch.func, req_ch.request_size, req_ch.free_offset}));
				words_in++;
				if (stack_depth[SHADOW] == spadf_pkg::MAX_BLOCKS_DEF)
					full_depth_seen++;
			end
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result word with no request outstanding");
					errors++;
				end else begin
					status_seen[pending_results[0].status]++;
					if (pending_results[0].deferred)
						deferred_seen++;
					check_result(pending_results.pop_front());
				end
			end
		end
	end

	initial begin
		logic [spadf_pkg::SIZE_W-1:0] caps [10];
		int                           alloc_pcts [10];
		caps = '{spadf_pkg::CAP_RESET, 22'd4, 22'd0, 22'h3FFFFF, 22'd1000,
			spadf_pkg::CAP_RESET, spadf_pkg::SIZE_W'($urandom_range(32'h3FFFFF)), 22'd64,
			spadf_pkg::CAP_RESET, 22'd512};
		alloc_pcts = '{85, 40, 60, 70, 50, 45, 60, 75, 55, 50};
		for (int m = 0; m < 2; m++) begin
			stack_depth[m] = 0;
			pool_top[m] = 0;
			pool_cap[m] = spadf_pkg::CAP_RESET;
		end
		for (int s = 0; s < 4; s++)
			status_seen[s] = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FN_ALLOC;
		req_ch.request_size = '0;
		req_ch.free_offset = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty stack, zero sizes sharing offsets, rounding, deferred frees and
		// the cascade, the whole pool, the address limit and oversize requests.
		queue_request(FN_FREE, '0, '0);
		queue_request(FN_ALLOC, 22'd0, '0);
		queue_request(FN_ALLOC, 22'd1, '0);
		queue_request(FN_ALLOC, 22'd0, '0);
		queue_request(FN_ALLOC, 22'd5, '0);
		queue_request(FN_FREE, '0, 21'd4);
		queue_request(FN_FREE, '0, 21'd0);
		queue_request(FN_FREE, '0, 21'd0);
		queue_request(FN_FREE, '0, 21'd0);
		queue_request(FN_FREE, '0, 21'd4);
		queue_request(FN_ALLOC, 22'h3FFFFF, '0);
		queue_request(FN_ALLOC, 22'd2097152, '0);
		queue_request(FN_ALLOC, 22'd0, '0);
		queue_request(FN_FREE, 22'h3FFFFF, 21'h1FFFFF);
		queue_request(FN_FREE, '0, 21'd0);
		queue_request(FN_ALLOC, 22'd2097149, 21'h1FFFFF);
		queue_request(FN_FREE, '0, 21'd0);
		queue_request(FN_ALLOC, 22'h2AAAAA, 21'h0AAAAA);
		queue_request(FN_FREE, 22'h155555, 21'h0AAAAA);
		queue_request(FN_FREE, 22'h2AAAAA, 21'h155555);
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			write_capacity(caps[p]);
			no_idle = (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Sender stops mid-phase until every result is back.
				if (p == 5 && n == PHASE_ITEMS / 2)
					wait_drained();
				queue_random(alloc_pcts[p]);
			end
			if (p == 3)
				hold_asks++;
			wait_drained();
		end
		no_idle = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d request words checked: %0d ok, %0d no room, %0d not found, %0d stack full",
			words_in, status_seen[spadf_pkg::ST_OK], status_seen[spadf_pkg::ST_NOROOM],
			status_seen[spadf_pkg::ST_NOTFOUND], status_seen[spadf_pkg::ST_FULL]);
		$display("%0d deferred frees, %0d words at full depth, %0d capacity writes, %0d errors",
			deferred_seen, full_depth_seen, cap_writes, errors);
		if (errors == 0) begin
			$display("tb_stack_pool_allocator_deferred_free OK");
		end else begin
			$display("tb_stack_pool_allocator_deferred_free NOT OK");
		end
		$finish;
	end

endmodule
